// ===== src/word_tokenizer_case_class_macros.svh =====
// Assertion macros for the tokenizer checker.
`ifndef WORD_TOKENIZER_CASE_CLASS_MACROS_SVH
`define WORD_TOKENIZER_CASE_CLASS_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WTCC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WTCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== src/wtcc_pkg.sv =====
// Types, class codes and byte helpers for the word tokenizer.
package wtcc_pkg;

  localparam logic [2:0] CLS_NONLETTER = 3'd0;
  localparam logic [2:0] CLS_LOWER     = 3'd1;
  localparam logic [2:0] CLS_CAPITAL   = 3'd2;
  localparam logic [2:0] CLS_ALLCAPS   = 3'd3;
  localparam logic [2:0] CLS_PASS      = 3'd4;

  localparam int MinWord = 3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic [2:0] token_class;
    logic       last_of_token;
  } out_beat_t;

  // Broadcast to every cell of the byte chain.
  typedef struct packed {
    logic       shift;
    logic [7:0] data;
  } cell_ctrl_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'd65) && (c <= 8'd90);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

endpackage

// ===== src/wtcc_cell.sv =====
// One byte cell of the token chain: load from the input or take the neighbor's byte.
module wtcc_cell (
  input  logic                 clk_i,
  input  wtcc_pkg::cell_ctrl_t ctrl_i,
  input  logic                 wr_en_i,
  input  logic [7:0]           next_i,
  output logic [7:0]           byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (wr_en_i) begin
      byte_d = ctrl_i.data;
    end else if (ctrl_i.shift) begin
      byte_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== src/word_tokenizer_case_class.sv =====
// Top level of the word tokenizer with capitalization class.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------------------------
//   in      | in_valid_i | in_stall_o  | in_data_i  (char_code, end_of_input)
//   out     | out_valid_o| out_stall_i | out_data_o (token_byte, token_class, last)
//
// A byte that joins the pending run is written into the next free cell. A
// byte or end mark that closes a run latches its class and starts a drain:
// the byte chain shifts one byte a cycle into the output register while the
// output does not stall. Reset empties the run and the output register; the
// chain bytes need no reset. Output stalls hold the drain; input is stalled
// only while a run drains.
module word_tokenizer_case_class #(
  parameter int TOKEN_LIMIT = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wtcc_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wtcc_pkg::out_beat_t out_data_o
);

  localparam int RunMax = TOKEN_LIMIT - 1;
  localparam int LenW   = $clog2(TOKEN_LIMIT);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam logic [LenW-1:0] RunMaxL  = LenW'(RunMax);
  localparam logic [LenW-1:0] MinWordL = LenW'(wtcc_pkg::MinWord);
  localparam logic [LenW-1:0] OneL     = LenW'(1);

  logic                state_q, state_d;
  logic [LenW-1:0]     len_q, len_d;       // bytes in the pending run
  logic [LenW-1:0]     upc_q, upc_d;       // upper-case letters in the run
  logic [LenW-1:0]     remain_q, remain_d; // bytes still to drain
  logic                first_up_q, first_up_d;
  logic                letters_q, letters_d;
  logic [7:0]          pend_q, pend_d;     // byte that opens the next run
  logic                pend_vld_q, pend_vld_d;
  logic [2:0]          cls_q, cls_d;
  logic                out_valid_q, out_valid_d;
  wtcc_pkg::out_beat_t out_q, out_d;

  logic                 in_acc, eoi, need_emit, out_free, full;
  logic [7:0]           c;
  logic [2:0]           cls_now;
  logic                 app_en;
  logic [LenW-1:0]      app_base;
  wtcc_pkg::cell_ctrl_t ctrl;
  logic [7:0]           cell_byte [RunMax];

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign c          = in_data_i.char_code;
  assign eoi        = in_data_i.end_of_input;
  assign full       = (len_q >= RunMaxL);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Close the run on end of input, a full run, or a letter/non-letter switch.
  assign need_emit = (len_q != '0) &&
                     (eoi || full || (wtcc_pkg::is_letter(c) != letters_q));

  // Classify the pending run from its counters.
  always_comb begin
    if (!letters_q) begin
      cls_now = wtcc_pkg::CLS_NONLETTER;
    end else if ((len_q < MinWordL) || (len_q == RunMaxL)) begin
      cls_now = wtcc_pkg::CLS_PASS;
    end else if (upc_q == '0) begin
      cls_now = wtcc_pkg::CLS_LOWER;
    end else if ((upc_q == OneL) && first_up_q) begin
      cls_now = wtcc_pkg::CLS_CAPITAL;
    end else if (upc_q == len_q) begin
      cls_now = wtcc_pkg::CLS_ALLCAPS;
    end else begin
      cls_now = wtcc_pkg::CLS_PASS;
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    upc_d       = upc_q;
    remain_d    = remain_q;
    first_up_d  = first_up_q;
    letters_d   = letters_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    cls_d       = cls_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctrl.shift  = 1'b0;
    ctrl.data   = c;
    app_en      = 1'b0;
    app_base    = len_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (need_emit) begin
            // Latch the class and hold the new byte until the run drains.
            state_d    = ST_DRAIN;
            remain_d   = len_q;
            cls_d      = cls_now;
            pend_d     = c;
            pend_vld_d = !eoi;
          end else if (!eoi) begin
            app_en = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          // Advance the chain one byte into the output register.
          out_valid_d         = 1'b1;
          out_d.token_byte    = cell_byte[0];
          out_d.token_class   = cls_q;
          out_d.last_of_token = (remain_q == OneL);
          ctrl.shift          = 1'b1;
          remain_d            = remain_q - OneL;
          if (remain_q == OneL) begin
            state_d    = ST_IDLE;
            len_d      = '0;
            upc_d      = '0;
            first_up_d = 1'b0;
            letters_d  = 1'b0;
            pend_vld_d = 1'b0;
            // Start the next run with the held byte at the head cell.
            ctrl.data  = pend_q;
            app_base   = '0;
            app_en     = pend_vld_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (app_en) begin
      len_d = app_base + OneL;
      if (app_base == '0) begin
        letters_d  = wtcc_pkg::is_letter(ctrl.data);
        first_up_d = wtcc_pkg::is_upper(ctrl.data);
        upc_d      = LenW'(wtcc_pkg::is_upper(ctrl.data));
      end else begin
        upc_d = upc_q + LenW'(wtcc_pkg::is_upper(ctrl.data));
      end
    end
  end

  for (genvar i = 0; i < RunMax; i++) begin : g_cell
    logic [7:0] next_byte;
    if (i < RunMax - 1) begin : g_mid
      assign next_byte = cell_byte[i+1];
    end else begin : g_end
      assign next_byte = cell_byte[i];
    end
    wtcc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .wr_en_i (app_en && (app_base == LenW'(i))),
      .next_i  (next_byte),
      .byte_o  (cell_byte[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      upc_q       <= '0;
      remain_q    <= '0;
      first_up_q  <= 1'b0;
      letters_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      upc_q       <= upc_d;
      remain_q    <= remain_d;
      first_up_q  <= first_up_d;
      letters_q   <= letters_d;
      pend_vld_q  <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    cls_q  <= cls_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/wtcc_checker.sv =====
// Port-level checks for the word tokenizer, bound to the top level.
`include "word_tokenizer_case_class_macros.svh"

module wtcc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input wtcc_pkg::in_beat_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input wtcc_pkg::out_beat_t out_data_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // A stalled result beat holds.
  `WTCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Input stalls only after a beat was taken that closes a run.
  `WTCC_ASSERT_SAME(a_stall_cause, $rose(in_stall_o), $past(in_beat))

  // Input opens again only with the closing byte of the token on offer.
  `WTCC_ASSERT_SAME(a_drain_end, $fell(in_stall_o), out_valid_o && out_data_o.last_of_token)

  // Only defined class codes appear.
  `WTCC_ASSERT_SAME(a_class_code, out_valid_o, out_data_o.token_class <= wtcc_pkg::CLS_PASS)

endmodule

bind word_tokenizer_case_class wtcc_checker u_wtcc_checker (.*);
